// ===== src/fst_pkg.sv =====
// Shared constants, beat types, codes and controller/datapath interface types.
package fst_pkg;

	localparam int MAX_FRAMES    = 64;
	localparam int DURATION_BITS = 16;
	localparam int LIMIT_FRAMES  = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;

	localparam int OP_W       = 3;
	localparam int TIME_W     = 24;
	localparam int FRAME_W    = 6;
	localparam int IN_DUR_W   = 16;
	localparam int COUNT_W    = 7;
	localparam int SPEED_W    = 16;
	localparam int FRAC_BITS  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int ADDR_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PROD_W   = DURATION_BITS + SPEED_W;
	localparam int SH_W     = PROD_W - FRAC_BITS;
	localparam int TOTAL_W  = TIME_W + $clog2(LIMIT_FRAMES);
	localparam int DIVCNT_W = $clog2(TIME_W);

	localparam logic [TIME_W-1:0]     TIME_MAX         = '1;
	localparam logic [COUNT_W-1:0]    FRAME_COUNT_RST  = 7'd1;
	localparam logic [SPEED_W-1:0]    SPEED_RST        = 16'd256;
	localparam logic                  PAUSED_RST       = 1'b1;
	localparam logic [IN_DUR_W-1:0]   DEFAULT_DUR_RST  = 16'd1000;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_BACKWARD = 3'd1,
		OP_JUMP     = 3'd2,
		OP_NEXT     = 3'd3,
		OP_PREV     = 3'd4,
		OP_WRITE    = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_COUNT  = 2'd0,
		CFG_SPEED        = 2'd1,
		CFG_PAUSED       = 2'd2,
		CFG_DEFAULT_DUR  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [TIME_W-1:0]   amount;
		logic [FRAME_W-1:0]  frame_index;
		logic [IN_DUR_W-1:0] duration;
	} cmd_beat_t;

	typedef struct packed {
		logic [FRAME_W-1:0] current_frame;
		logic [TIME_W-1:0]  time_left;
	} res_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH_RD,
		ST_FETCH_MUL,
		ST_USE,
		ST_TOTAL,
		ST_DIV,
		ST_FINISH
	} fsm_state_t;

	typedef enum logic [1:0] {
		PH_SELECT,
		PH_BACK,
		PH_WALK,
		PH_SUM
	} fetch_phase_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_TICK_SHORT,
		DP_TICK_LONG,
		DP_SELECT,
		DP_MEM_WRITE,
		DP_USE_SELECT,
		DP_BACK_MOVE,
		DP_BACK_STAY,
		DP_SUM_CLEAR,
		DP_SUM_ACC,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_WALK_STEP,
		DP_WALK_END,
		DP_FINISH
	} dp_action_t;

	typedef struct packed {
		dp_action_t action;
		logic       addr_sum;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic paused;
		logic amt_lt_rem;
		logic back_moves;
		logic total_valid;
		logic sum_last;
		logic left_ge_total;
		logic div_last;
		logic left_ge_sc;
		logic res_free;
	} dp_status_t;

endpackage

// ===== src/fst_ctrl.sv =====
// Sequencing state machine: issues one datapath action per cycle.
module fst_ctrl
	import fst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  dp_status_t status,
	output ctrl_cmd_t  ctrl,
	output logic       busy
);

	fsm_state_t   state_q, state_d;
	fetch_phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SELECT;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (status.op)
					OP_TICK: begin
						if (status.paused || status.amt_lt_rem) state_d = ST_FINISH;
						else state_d = ST_TOTAL;
					end
					OP_BACKWARD: begin
						state_d = ST_FETCH_RD;
						phase_d = PH_BACK;
					end
					OP_JUMP, OP_NEXT, OP_PREV: begin
						state_d = ST_FETCH_RD;
						phase_d = PH_SELECT;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_FETCH_RD:  state_d = ST_FETCH_MUL;
			ST_FETCH_MUL: state_d = ST_USE;
			ST_USE: begin
				case (phase_q)
					PH_SELECT: state_d = ST_FINISH;
					PH_BACK: begin
						if (status.back_moves) state_d = ST_TOTAL;
						else state_d = ST_FINISH;
					end
					PH_SUM: begin
						if (status.sum_last) state_d = ST_TOTAL;
						else state_d = ST_FETCH_RD;
					end
					PH_WALK: begin
						if (status.left_ge_sc) state_d = ST_FETCH_RD;
						else state_d = ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_TOTAL: begin
				if (!status.total_valid) begin
					state_d = ST_FETCH_RD;
					phase_d = PH_SUM;
				end else if (status.left_ge_total) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_FETCH_RD;
					phase_d = PH_WALK;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_FETCH_RD;
					phase_d = PH_WALK;
				end
			end
			ST_FINISH: begin
				if (status.res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl.action   = DP_NONE;
		ctrl.addr_sum = (phase_q == PH_SUM);
		busy          = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) ctrl.action = DP_LOAD;
			end
			ST_DECODE: begin
				case (status.op)
					OP_TICK: begin
						if (status.paused) ctrl.action = DP_NONE;
						else if (status.amt_lt_rem) ctrl.action = DP_TICK_SHORT;
						else ctrl.action = DP_TICK_LONG;
					end
					OP_JUMP, OP_NEXT, OP_PREV: ctrl.action = DP_SELECT;
					OP_WRITE: ctrl.action = DP_MEM_WRITE;
					default: ctrl.action = DP_NONE;
				endcase
			end
			ST_USE: begin
				case (phase_q)
					PH_SELECT: ctrl.action = DP_USE_SELECT;
					PH_BACK: ctrl.action = status.back_moves ? DP_BACK_MOVE : DP_BACK_STAY;
					PH_SUM: ctrl.action = DP_SUM_ACC;
					PH_WALK: ctrl.action = status.left_ge_sc ? DP_WALK_STEP : DP_WALK_END;
					default: ctrl.action = DP_NONE;
				endcase
			end
			ST_TOTAL: begin
				if (!status.total_valid) ctrl.action = DP_SUM_CLEAR;
				else if (status.left_ge_total) ctrl.action = DP_DIV_INIT;
				else ctrl.action = DP_NONE;
			end
			ST_DIV: ctrl.action = DP_DIV_STEP;
			ST_FINISH: begin
				if (status.res_free) ctrl.action = DP_FINISH;
			end
			default: ctrl.action = DP_NONE;
		endcase
	end

endmodule

// ===== src/fst_dpath.sv =====
// Datapath: configuration, duration table, scaler, cycle total, modulo and result register.
module fst_dpath
	import fst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_beat_t             cmd,
	input  logic                  res_stall,
	input  ctrl_cmd_t             ctrl,
	output dp_status_t            status,
	output res_beat_t             res,
	output logic                  res_valid
);

	// configuration
	logic [COUNT_W-1:0]  frame_count_q;
	logic [SPEED_W-1:0]  speed_q;
	logic                paused_q;
	logic [IN_DUR_W-1:0] default_dur_q;

	// sequence state
	logic [FRAME_W-1:0] frame_q;
	logic [TIME_W-1:0]  rem_q;
	logic               total_valid_q;
	logic               res_valid_q;
	res_beat_t          res_q;

	// working registers
	op_t                 op_q;
	logic [TIME_W-1:0]   amt_q;
	logic [FRAME_W-1:0]  idx_q;
	logic [IN_DUR_W-1:0] dur_q;
	logic [TIME_W-1:0]   left_q;
	logic [TIME_W-1:0]   div_r_q;
	logic [DIVCNT_W-1:0] div_cnt_q;
	logic [FRAME_W-1:0]  sum_idx_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [DURATION_BITS-1:0] dur_mem_q [MAX_FRAMES];
	logic [DURATION_BITS-1:0] rd_data_q;
	logic [PROD_W-1:0]        prod_q;

	logic [COUNT_W-1:0] n;
	logic [FRAME_W-1:0] n_m1;
	logic [FRAME_W-1:0] after_f, before_f, step_f, target_f, clamp_f;
	logic [SH_W-1:0]    shifted;
	logic [TIME_W-1:0]  sc;
	logic [TIME_W-1:0]  spent;
	logic [ADDR_W-1:0]  rd_addr;
	logic               fwd;
	logic [TIME_W:0]    trial;
	logic [TIME_W-1:0]  div_next;

	// frames in use: zero acts as one, clip at the table bound
	always_comb begin
		n = frame_count_q;
		if (n == '0) n = COUNT_W'(1);
		if (n > COUNT_W'(LIMIT_FRAMES)) n = COUNT_W'(LIMIT_FRAMES);
	end
	assign n_m1 = FRAME_W'(n - COUNT_W'(1));

	assign after_f  = ((COUNT_W'(frame_q) + COUNT_W'(1)) >= n) ? '0 : frame_q + FRAME_W'(1);
	assign before_f = (frame_q == '0) ? n_m1 : frame_q - FRAME_W'(1);
	assign clamp_f  = (COUNT_W'(frame_q) >= n) ? n_m1 : frame_q;
	assign fwd      = (op_q == OP_TICK);
	assign step_f   = fwd ? after_f : before_f;

	always_comb begin
		case (op_q)
			OP_JUMP: target_f = (COUNT_W'(idx_q) >= n) ? n_m1 : idx_q;
			OP_NEXT: target_f = after_f;
			OP_PREV: target_f = before_f;
			default: target_f = frame_q;
		endcase
	end

	// scaled duration: drop the fraction, saturate, hold to at least one
	assign shifted = prod_q[PROD_W-1:FRAC_BITS];
	always_comb begin
		if (shifted > SH_W'(TIME_MAX)) sc = TIME_MAX;
		else if (shifted == '0) sc = TIME_W'(1);
		else sc = TIME_W'(shifted);
	end

	assign spent = (rem_q >= sc) ? '0 : sc - rem_q;

	// one restoring remainder step
	assign trial    = {div_r_q, left_q[TIME_W-1]};
	assign div_next = (TOTAL_W'(trial) >= total_q) ?
		TIME_W'(TOTAL_W'(trial) - total_q) : TIME_W'(trial);

	assign rd_addr = ctrl.addr_sum ? ADDR_W'(sum_idx_q) : ADDR_W'(frame_q);

	// duration table and scaler pipeline
	always_ff @(posedge clk) begin
		if (ctrl.action == DP_MEM_WRITE && 32'(idx_q) < MAX_FRAMES) begin
			dur_mem_q[ADDR_W'(idx_q)] <=
				DURATION_BITS'((dur_q == '0) ? default_dur_q : dur_q);
		end
		rd_data_q <= dur_mem_q[rd_addr];
		prod_q    <= PROD_W'(rd_data_q) * PROD_W'(speed_q);
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			speed_q       <= SPEED_RST;
			paused_q      <= PAUSED_RST;
			default_dur_q <= DEFAULT_DUR_RST;
			frame_q       <= '0;
			rem_q         <= '0;
			total_valid_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_valid_q <= 1'b0;
				case (cfg_reg_t'(cfg_index))
					CFG_FRAME_COUNT: frame_count_q <= cfg_data[COUNT_W-1:0];
					CFG_SPEED:       speed_q       <= cfg_data[SPEED_W-1:0];
					CFG_PAUSED:      paused_q      <= cfg_data[0];
					CFG_DEFAULT_DUR: default_dur_q <= cfg_data[IN_DUR_W-1:0];
					default: ;
				endcase
			end
			if (ctrl.action == DP_FINISH) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			case (ctrl.action)
				DP_LOAD:       frame_q <= clamp_f;
				DP_TICK_SHORT: rem_q <= rem_q - amt_q;
				DP_TICK_LONG:  frame_q <= after_f;
				DP_SELECT:     frame_q <= target_f;
				DP_MEM_WRITE:  total_valid_q <= 1'b0;
				DP_USE_SELECT: rem_q <= sc;
				DP_BACK_MOVE:  frame_q <= before_f;
				DP_BACK_STAY:  rem_q <= sc - (spent - amt_q);
				DP_SUM_ACC: begin
					if (sum_idx_q == n_m1) total_valid_q <= 1'b1;
				end
				DP_WALK_STEP:  frame_q <= step_f;
				DP_WALK_END:   rem_q <= fwd ? sc - left_q : left_q;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.action)
			DP_LOAD: begin
				op_q  <= op_t'(cmd.operation);
				amt_q <= cmd.amount;
				idx_q <= cmd.frame_index;
				dur_q <= cmd.duration;
			end
			DP_TICK_LONG: left_q <= amt_q - rem_q;
			DP_BACK_MOVE: left_q <= amt_q - spent;
			DP_SUM_CLEAR: begin
				total_q   <= '0;
				sum_idx_q <= '0;
			end
			DP_SUM_ACC: begin
				total_q   <= total_q + TOTAL_W'(sc);
				sum_idx_q <= sum_idx_q + FRAME_W'(1);
			end
			DP_DIV_INIT: begin
				div_r_q   <= '0;
				div_cnt_q <= '0;
			end
			DP_DIV_STEP: begin
				div_r_q   <= div_next;
				div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
				if (div_cnt_q == DIVCNT_W'(TIME_W - 1)) left_q <= div_next;
				else left_q <= {left_q[TIME_W-2:0], 1'b0};
			end
			DP_WALK_STEP: left_q <= left_q - sc;
			DP_FINISH: begin
				res_q.current_frame <= frame_q;
				res_q.time_left     <= rem_q;
			end
			default: ;
		endcase
	end

	assign status.op            = op_q;
	assign status.paused        = paused_q;
	assign status.amt_lt_rem    = (amt_q < rem_q);
	assign status.back_moves    = (amt_q >= spent);
	assign status.total_valid   = total_valid_q;
	assign status.sum_last      = (sum_idx_q == n_m1);
	assign status.left_ge_total = (TOTAL_W'(left_q) >= total_q);
	assign status.div_last      = (div_cnt_q == DIVCNT_W'(TIME_W - 1));
	assign status.left_ge_sc    = (left_q >= sc);
	assign status.res_free      = !res_valid_q || !res_stall;

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== src/frame_sequence_timer.sv =====
// Top level of the frame sequence timer: controller and datapath.
//
// Command channel (cmd_valid, cmd_stall, cmd): one beat is one operation; a beat
// is taken at a clock edge with cmd_valid high and cmd_stall low. cmd_stall is
// high while an operation is in progress; exactly one operation runs at a time.
// Result channel (res_valid, res_stall, res): one beat per command beat giving
// the frame now shown and the scaled time left in it, in command order.
// Write, unknown codes, paused ticks and ticks inside the current frame go
// straight from decode to the result; jump, next, prev and a backward step
// inside the frame first read and scale one duration. A crossing tick and a
// crossing backward step add, for each further boundary, a table read, a 16x16
// scale multiply and a compare. Both also need the cycle total: after any
// configuration or duration write it is rebuilt first, with one table read and
// scale per frame in use; an amount beyond one whole cycle adds a remainder pass.
// A finished result sits in the output register; while res_stall is high the
// block holds it, takes one more command and holds that result back until the
// register is free, keeping cmd_stall high meanwhile. Reset (arst_n low) returns
// frame 0 with time 0 and the register defaults; the duration table holds
// nothing defined until written and is not cleared. Configuration writes (cfg_we,
// cfg_index, cfg_data) land at once; the user writes only while idle, unenforced.
module frame_sequence_timer
	import fst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_beat_t             cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_beat_t             res
);

	ctrl_cmd_t  ctrl;
	dp_status_t status;
	logic       busy;

	// sequencer: decides the next datapath action from the status flags
	fst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.status    (status),
		.ctrl      (ctrl),
		.busy      (busy)
	);

	// hold off new beats until the current operation has handed its result over
	assign cmd_stall = busy;

	fst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res_stall (res_stall),
		.ctrl      (ctrl),
		.status    (status),
		.res       (res),
		.res_valid (res_valid)
	);

endmodule
